@@ sv/t4f_pkg.sv @@
package t4f_pkg;

    localparam int NODES = 4;
    localparam int SLOT_W = $clog2(NODES);
    localparam int CNT_W = $clog2(NODES + 1);

    // configuration register indexes
    localparam logic [1:0] CFG_LAMBDA = 2'd0;
    localparam logic [1:0] CFG_SHEAR  = 2'd1;

    localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
    localparam logic signed [49:0] SAT_HI = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] SAT_LO = 50'sh3_8000_0000_0000;

    // divide by six: halve, then multiply by ceil(2^34/3) and keep bits 34 and up
    localparam logic [32:0] DIV3_RECIP = 33'd5726623062;
    localparam int DIV3_SHIFT = 34;
    // magnitudes at or above 6 * 2^31 saturate the force
    localparam logic [47:0] DIV_LIMIT = 48'd12884901888;

    typedef struct packed {
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic signed [31:0] grad_z;
        logic signed [31:0] disp_x;
        logic signed [31:0] disp_y;
        logic signed [31:0] disp_z;
        logic signed [31:0] jacobian_det;
        logic               last_node;
        logic               contrib;
        logic [SLOT_W-1:0]  slot;
        logic [CNT_W-1:0]   nodes;
    } t_item;

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        logic signed [47:0] r;
        if (v > SAT_HI) begin
            r = MAX48;
        end else if (v < SAT_LO) begin
            r = MIN48;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    function automatic logic signed [47:0] add48(input logic signed [47:0] a,
                                                 input logic signed [47:0] b);
        logic signed [49:0] s;
        s = 50'(a) + 50'(b);
        return sat48(s);
    endfunction

endpackage

@@ sv/t4f_queue.sv @@
module t4f_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t4f_pkg::t_item  i_item,
    output logic            o_full,
    output logic            o_valid,
    output t4f_pkg::t_item  o_item,
    input  logic            i_pop
);
    import t4f_pkg::*;

    t_item       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

@@ sv/t4f_front.sv @@
module t4f_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_grad_x,
    input  logic signed [31:0] i_grad_y,
    input  logic signed [31:0] i_grad_z,
    input  logic signed [31:0] i_disp_x,
    input  logic signed [31:0] i_disp_y,
    input  logic signed [31:0] i_disp_z,
    input  logic signed [31:0] i_jacobian_det,
    input  logic               i_last_node,
    output logic               o_push,
    output t4f_pkg::t_item     o_item,
    input  logic               i_full
);
    import t4f_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic             contrib;

    // node slot free while fewer than NODES are held
    assign contrib = (r_cnt < CNT_W'(NODES));
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item.grad_x       = i_grad_x;
        o_item.grad_y       = i_grad_y;
        o_item.grad_z       = i_grad_z;
        o_item.disp_x       = i_disp_x;
        o_item.disp_y       = i_disp_y;
        o_item.disp_z       = i_disp_z;
        o_item.jacobian_det = i_jacobian_det;
        o_item.last_node    = i_last_node;
        o_item.contrib      = contrib;
        o_item.slot         = r_cnt[SLOT_W-1:0];
        o_item.nodes        = contrib ? r_cnt + CNT_W'(1) : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_push) begin
            if (i_last_node) begin
                r_cnt <= '0;
            end else if (contrib) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

endmodule

@@ sv/t4f_mul.sv @@
module t4f_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [48:0] i_a,
    input  logic signed [48:0] i_b,
    output logic               o_done,
    output logic signed [47:0] o_res,
    output logic [95:0]        o_raw
);
    import t4f_pkg::*;

    logic        r_run;
    logic [2:0]  r_ph;
    logic        r_neg;
    logic [47:0] r_ma;
    logic [47:0] r_mb;
    logic [63:0] r_pp;
    logic [95:0] r_acc;
    logic        r_done;
    logic signed [47:0] r_res;

    logic [48:0] abs_a;
    logic [48:0] abs_b;
    logic [15:0] chunk;
    logic [95:0] pp_sh;
    logic        big;
    logic [47:0] mag;

    assign abs_a = i_a[48] ? 49'(-i_a) : 49'(i_a);
    assign abs_b = i_b[48] ? 49'(-i_b) : 49'(i_b);

    always_comb begin
        case (r_ph)
            3'd0:    chunk = r_mb[15:0];
            3'd1:    chunk = r_mb[31:16];
            default: chunk = r_mb[47:32];
        endcase
        case (r_ph)
            3'd1:    pp_sh = {32'd0, r_pp};
            3'd2:    pp_sh = {16'd0, r_pp, 16'd0};
            default: pp_sh = {r_pp, 32'd0};
        endcase
    end

    // product shifted down by 16 saturates once it reaches 2^47
    assign big = |r_acc[95:63];
    assign mag = {1'b0, r_acc[62:16]};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_a[48] ^ i_b[48];
            r_ma  <= abs_a[47:0];
            r_mb  <= abs_b[47:0];
            r_acc <= '0;
        end else if (r_run) begin
            if (r_ph <= 3'd2) begin
                r_pp <= r_ma * chunk;
            end
            if (r_ph != 3'd0 && r_ph <= 3'd3) begin
                r_acc <= r_acc + pp_sh;
            end
            if (r_ph == 3'd4) begin
                if (r_neg) begin
                    r_res <= big ? MIN48 : -$signed(mag);
                end else begin
                    r_res <= big ? MAX48 : $signed(mag);
                end
            end
        end
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_ph   <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && (r_ph == 3'd4);
            if (i_start) begin
                r_run <= 1'b1;
                r_ph  <= 3'd0;
            end else if (r_run) begin
                if (r_ph == 3'd4) begin
                    r_run <= 1'b0;
                end
                r_ph <= r_ph + 3'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_raw  = r_acc;

endmodule

@@ sv/t4f_back.sv @@
module t4f_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  t4f_pkg::t_item     i_q_item,
    input  logic [30:0]        i_lambda,
    input  logic [30:0]        i_shear,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_node_index,
    output logic signed [31:0] o_force_x,
    output logic signed [31:0] o_force_y,
    output logic signed [31:0] o_force_z,
    output logic               o_last_force
);
    import t4f_pkg::*;

    typedef enum logic [1:0] {B_IDLE, B_ISSUE, B_WAIT, B_OUT} t_bstate;
    typedef enum logic [1:0] {PH_ACC, PH_STR, PH_NODE} t_phase;

    t_bstate            r_state;
    t_phase             r_ph;
    logic [3:0]         r_k;
    t_item              r_it;
    logic signed [47:0] r_e [6];
    logic signed [47:0] r_s [6];
    logic signed [31:0] r_gx [NODES];
    logic signed [31:0] r_gy [NODES];
    logic signed [31:0] r_gz [NODES];
    logic signed [47:0] r_tmp;
    logic signed [47:0] r_t;
    logic signed [47:0] r_p;
    logic [SLOT_W-1:0]  r_nd;
    logic signed [31:0] r_fx;
    logic signed [31:0] r_fy;
    logic signed [31:0] r_fz;

    logic               mul_start;
    logic signed [48:0] op_a;
    logic signed [48:0] op_b;
    logic               mul_done;
    logic signed [47:0] mul_res;
    logic [95:0]        mul_raw;

    logic [33:0]        l2mu;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic [47:0]        pm;
    logic               big;
    logic [30:0]        quo;
    logic signed [31:0] fval;
    logic signed [49:0] shear_sum;
    logic               last_out;

    t4f_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (mul_done),
        .o_res   (mul_res),
        .o_raw   (mul_raw)
    );

    assign mul_start = (r_state == B_ISSUE);
    assign o_q_pop   = (r_state == B_IDLE) && i_q_valid;
    assign l2mu      = 34'(i_lambda) + {2'b0, i_shear, 1'b0};
    assign nx        = r_gx[r_nd];
    assign ny        = r_gy[r_nd];
    assign nz        = r_gz[r_nd];

    // divide by six of the detJ product, sign flipped, clipped to 32 bits
    assign pm   = r_p[47] ? 48'(-r_p) : 48'(r_p);
    assign big  = (pm >= DIV_LIMIT);
    assign quo  = mul_raw[DIV3_SHIFT+30:DIV3_SHIFT];
    always_comb begin
        if (big) begin
            fval = r_p[47] ? MAX32 : MIN32;
        end else if (r_p[47]) begin
            fval = $signed({1'b0, quo});
        end else begin
            fval = -$signed({1'b0, quo});
        end
    end

    assign shear_sum = 50'(r_e[(r_k == 4'd4) ? 3'd3 : ((r_k == 4'd6) ? 3'd4 : 3'd5)])
                       + 50'(r_tmp) + 50'(mul_res);

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_ph)
            PH_ACC: begin
                case (r_k)
                    4'd0: begin op_a = 49'(r_it.grad_x); op_b = 49'(r_it.disp_x); end
                    4'd1: begin op_a = 49'(r_it.grad_y); op_b = 49'(r_it.disp_y); end
                    4'd2: begin op_a = 49'(r_it.grad_z); op_b = 49'(r_it.disp_z); end
                    4'd3: begin op_a = 49'(r_it.grad_y); op_b = 49'(r_it.disp_x); end
                    4'd4: begin op_a = 49'(r_it.grad_x); op_b = 49'(r_it.disp_y); end
                    4'd5: begin op_a = 49'(r_it.grad_z); op_b = 49'(r_it.disp_y); end
                    4'd6: begin op_a = 49'(r_it.grad_y); op_b = 49'(r_it.disp_z); end
                    4'd7: begin op_a = 49'(r_it.grad_z); op_b = 49'(r_it.disp_x); end
                    default: begin op_a = 49'(r_it.grad_x); op_b = 49'(r_it.disp_z); end
                endcase
            end
            PH_STR: begin
                case (r_k)
                    4'd0: begin op_a = $signed(49'(l2mu)); op_b = 49'(r_e[0]); end
                    4'd1: begin
                        op_a = $signed(49'(i_lambda)); op_b = 49'(add48(r_e[1], r_e[2]));
                    end
                    4'd2: begin op_a = $signed(49'(l2mu)); op_b = 49'(r_e[1]); end
                    4'd3: begin
                        op_a = $signed(49'(i_lambda)); op_b = 49'(add48(r_e[0], r_e[2]));
                    end
                    4'd4: begin op_a = $signed(49'(l2mu)); op_b = 49'(r_e[2]); end
                    4'd5: begin
                        op_a = $signed(49'(i_lambda)); op_b = 49'(add48(r_e[1], r_e[0]));
                    end
                    4'd6: begin op_a = $signed(49'(i_shear)); op_b = 49'(r_e[3]); end
                    4'd7: begin op_a = $signed(49'(i_shear)); op_b = 49'(r_e[4]); end
                    default: begin op_a = $signed(49'(i_shear)); op_b = 49'(r_e[5]); end
                endcase
            end
            PH_NODE: begin
                case (r_k) inside
                    4'd0:  begin op_a = 49'(r_s[0]); op_b = 49'(nx); end
                    4'd1:  begin op_a = 49'(r_s[3]); op_b = 49'(ny); end
                    4'd2:  begin op_a = 49'(r_s[5]); op_b = 49'(nz); end
                    4'd5:  begin op_a = 49'(r_s[1]); op_b = 49'(ny); end
                    4'd6:  begin op_a = 49'(r_s[3]); op_b = 49'(nx); end
                    4'd7:  begin op_a = 49'(r_s[4]); op_b = 49'(nz); end
                    4'd10: begin op_a = 49'(r_s[2]); op_b = 49'(nz); end
                    4'd11: begin op_a = 49'(r_s[4]); op_b = 49'(ny); end
                    4'd12: begin op_a = 49'(r_s[5]); op_b = 49'(nx); end
                    4'd3, 4'd8, 4'd13: begin
                        op_a = 49'(r_it.jacobian_det); op_b = 49'(r_t);
                    end
                    4'd4, 4'd9, 4'd14: begin
                        op_a = $signed({2'b0, pm[47:1]});
                        op_b = $signed(49'(DIV3_RECIP));
                    end
                    default: begin op_a = '0; op_b = '0; end
                endcase
            end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign last_out = (CNT_W'(r_nd) + CNT_W'(1) == r_it.nodes);

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_it <= i_q_item;
        end
        if (r_state == B_WAIT && mul_done) begin
            case (r_ph)
                PH_ACC: begin
                    if (r_k == 4'd8) begin
                        r_gx[r_it.slot] <= r_it.grad_x;
                        r_gy[r_it.slot] <= r_it.grad_y;
                        r_gz[r_it.slot] <= r_it.grad_z;
                    end
                    if (r_k == 4'd3 || r_k == 4'd5 || r_k == 4'd7) begin
                        r_tmp <= mul_res;
                    end
                end
                PH_STR: begin
                    case (r_k) inside
                        4'd0, 4'd2, 4'd4: r_tmp <= mul_res;
                        4'd1: r_s[0] <= add48(r_tmp, mul_res);
                        4'd3: r_s[1] <= add48(r_tmp, mul_res);
                        4'd5: r_s[2] <= add48(r_tmp, mul_res);
                        4'd6: r_s[3] <= mul_res;
                        4'd7: r_s[4] <= mul_res;
                        default: r_s[5] <= mul_res;
                    endcase
                end
                default: begin
                    case (r_k) inside
                        4'd0, 4'd5, 4'd10:        r_tmp <= mul_res;
                        4'd1, 4'd6, 4'd11:        r_tmp <= add48(r_tmp, mul_res);
                        4'd2, 4'd7, 4'd12:        r_t   <= add48(r_tmp, mul_res);
                        4'd3, 4'd8, 4'd13:        r_p   <= mul_res;
                        4'd4:                     r_fx  <= fval;
                        4'd9:                     r_fy  <= fval;
                        default:                  r_fz  <= fval;
                    endcase
                end
            endcase
        end

        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ph    <= PH_ACC;
            r_k     <= '0;
            r_nd    <= '0;
            for (int i = 0; i < 6; i++) begin
                r_e[i] <= '0;
            end
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (i_q_valid) begin
                        r_k <= '0;
                        if (i_q_item.contrib) begin
                            r_ph    <= PH_ACC;
                            r_state <= B_ISSUE;
                        end else if (i_q_item.last_node) begin
                            r_ph    <= PH_STR;
                            r_state <= B_ISSUE;
                        end
                    end
                end
                B_ISSUE: begin
                    r_state <= B_WAIT;
                end
                B_WAIT: begin
                    if (mul_done) begin
                        r_k     <= r_k + 4'd1;
                        r_state <= B_ISSUE;
                        case (r_ph)
                            PH_ACC: begin
                                case (r_k)
                                    4'd0: r_e[0] <= add48(r_e[0], mul_res);
                                    4'd1: r_e[1] <= add48(r_e[1], mul_res);
                                    4'd2: r_e[2] <= add48(r_e[2], mul_res);
                                    4'd4: r_e[3] <= sat48(shear_sum);
                                    4'd6: r_e[4] <= sat48(shear_sum);
                                    4'd8: r_e[5] <= sat48(shear_sum);
                                    default: ;
                                endcase
                                if (r_k == 4'd8) begin
                                    r_k <= '0;
                                    if (r_it.last_node) begin
                                        r_ph <= PH_STR;
                                    end else begin
                                        r_state <= B_IDLE;
                                    end
                                end
                            end
                            PH_STR: begin
                                if (r_k == 4'd8) begin
                                    r_k  <= '0;
                                    r_nd <= '0;
                                    r_ph <= PH_NODE;
                                    for (int i = 0; i < 6; i++) begin
                                        r_e[i] <= '0;
                                    end
                                end
                            end
                            default: begin
                                if (r_k == 4'd14) begin
                                    r_state <= B_OUT;
                                end
                            end
                        endcase
                    end
                end
                B_OUT: begin
                    if (i_ready) begin
                        r_k <= '0;
                        if (last_out) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_nd    <= r_nd + SLOT_W'(1);
                            r_state <= B_ISSUE;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_valid      = (r_state == B_OUT);
    assign o_node_index = 2'(r_nd);
    assign o_force_x    = r_fx;
    assign o_force_y    = r_fy;
    assign o_force_z    = r_fz;
    assign o_last_force = last_out;

endmodule

@@ sv/tet4_internal_force.sv @@
// a node item takes a pop plus 9 multiplies
// a closing item adds the stress multiplies, then the node multiplies of each held node
// before that node's force, plus a handover per force
// the back end handles one item at a time on its single shared 48x16-per-cycle multiplier,
// while the queue in front of it holds up to two further items
// synchronous active-low reset clears counters, strains, moduli and the force-channel valid
module tet4_internal_force (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // node item channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_grad_x,
    input  logic signed [31:0] i_grad_y,
    input  logic signed [31:0] i_grad_z,
    input  logic signed [31:0] i_disp_x,
    input  logic signed [31:0] i_disp_y,
    input  logic signed [31:0] i_disp_z,
    input  logic signed [31:0] i_jacobian_det,
    input  logic               i_last_node,
    // force channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_node_index,
    output logic signed [31:0] o_force_x,
    output logic signed [31:0] o_force_y,
    output logic signed [31:0] o_force_z,
    output logic               o_last_force,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import t4f_pkg::*;

    logic [30:0] r_lambda;
    logic [30:0] r_shear;

    logic  q_push;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    t_item push_item;
    t_item head_item;

    // config transactions are always accepted, unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda <= '0;
            r_shear  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LAMBDA: r_lambda <= i_cfg_data[30:0];
                CFG_SHEAR:  r_shear  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // front: takes node transactions and tags slot, contribution and node count
    t4f_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_grad_x       (i_grad_x),
        .i_grad_y       (i_grad_y),
        .i_grad_z       (i_grad_z),
        .i_disp_x       (i_disp_x),
        .i_disp_y       (i_disp_y),
        .i_disp_z       (i_disp_z),
        .i_jacobian_det (i_jacobian_det),
        .i_last_node    (i_last_node),
        .o_push         (q_push),
        .o_item         (push_item),
        .i_full         (q_full)
    );

    // short queue decouples front and back
    t4f_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (head_item),
        .i_pop   (q_pop)
    );

    // back: strain accumulation, hooke's law and per-node force emission
    t4f_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_pop      (q_pop),
        .i_q_item     (head_item),
        .i_lambda     (r_lambda),
        .i_shear      (r_shear),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_node_index (o_node_index),
        .o_force_x    (o_force_x),
        .o_force_y    (o_force_y),
        .o_force_z    (o_force_z),
        .o_last_force (o_last_force)
    );

endmodule
